// File: hw/rtl/velocity_frame_rotation_macros.svh
// ----------------------------------------------------------------------------
// Velocity frame rotation assertion macros
// Shared concurrent assertion wrappers. Define NO_ASSERTIONS to compile
// them out. Each use names its label, an antecedent and a consequent.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_FRAME_ROTATION_MACROS_SVH
`define VELOCITY_FRAME_ROTATION_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and disabled during reset.
`define VFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("velocity_frame_rotation: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define VFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("velocity_frame_rotation: next-cycle check failed");

`else

`define VFR_ASSERT_IMPL(label, ante, cons)
`define VFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/vfr_pkg.sv
// ----------------------------------------------------------------------------
// vfr_pkg
// Widths, constants, shared types and the arctangent table of the velocity
// frame rotation block.
// ----------------------------------------------------------------------------
package vfr_pkg;

  // Velocity fields (signed Q3.12) and heading field widths.
  localparam int VEL_WIDTH = 16;
  localparam int HEAD_W    = 17;

  // Folded angle in hundredths of a degree, range -9000..9000.
  localparam int ANG_W       = 15;
  // The angle accumulator counts 1/256 of a hundredth degree.
  localparam int ANGLE_SHIFT = 8;
  localparam int ZW          = 24;

  // Gain compensation: round(2^30 / K), then a floor shift by 14.
  localparam int KINV_W     = 31;
  localparam logic signed [KINV_W-1:0] KINV = 31'sd652032874;
  localparam int KINV_SHIFT = 14;
  localparam int PROD_W     = VEL_WIDTH + 1 + KINV_W;

  // CORDIC datapath width: one headroom bit over the scaled product.
  localparam int XW         = PROD_W - KINV_SHIFT + 1;
  // Fraction bits below Q3.12 dropped by the final rounding.
  localparam int FRAC_SHIFT = 16;
  localparam int RW         = XW - FRAC_SHIFT;

  // Iteration count, limited by the length of the arctangent table.
  localparam int ROTATION_STEPS = 16;
  localparam int TABLE_LEN      = 24;
  localparam int CORDIC_STAGES  = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
  localparam int ATAN_IDX_W     = 5;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_OUTPUT = '0;

  // One vector in flight through the rotator.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vfr_vec_t;

  // atan(2^-i) in accumulator units, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0:    val = ZW'(1152000);
      5'd1:    val = ZW'(680065);
      5'd2:    val = ZW'(359328);
      5'd3:    val = ZW'(182400);
      5'd4:    val = ZW'(91554);
      5'd5:    val = ZW'(45822);
      5'd6:    val = ZW'(22916);
      5'd7:    val = ZW'(11459);
      5'd8:    val = ZW'(5730);
      5'd9:    val = ZW'(2865);
      5'd10:   val = ZW'(1432);
      5'd11:   val = ZW'(716);
      5'd12:   val = ZW'(358);
      5'd13:   val = ZW'(179);
      5'd14:   val = ZW'(90);
      5'd15:   val = ZW'(45);
      5'd16:   val = ZW'(22);
      5'd17:   val = ZW'(11);
      5'd18:   val = ZW'(6);
      5'd19:   val = ZW'(3);
      5'd20:   val = ZW'(1);
      5'd21:   val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/vfr_cordic.sv
// ----------------------------------------------------------------------------
// vfr_cordic
// Pipelined CORDIC rotator, one register stage per iteration, with a
// per-stage valid bit and a ready chain that fills bubbles.
// ----------------------------------------------------------------------------
module vfr_cordic
  import vfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  vfr_vec_t             up_vec,
  output logic                 up_ready,
  output logic                 dn_valid,
  output logic signed [XW-1:0] dn_x,
  output logic signed [XW-1:0] dn_y,
  input  logic                 dn_ready
);

  vfr_vec_t vec_r   [CORDIC_STAGES];
  vfr_vec_t vec_nxt [CORDIC_STAGES];
  logic     v_r     [CORDIC_STAGES];
  logic     rdy     [CORDIC_STAGES+1];

  assign rdy[CORDIC_STAGES] = dn_ready;
  assign up_ready           = rdy[0];
  assign dn_valid           = v_r[CORDIC_STAGES-1];
  assign dn_x               = vec_r[CORDIC_STAGES-1].x;
  assign dn_y               = vec_r[CORDIC_STAGES-1].y;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    vfr_vec_t             src;
    logic                 src_v;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    if (i == 0) begin : g_first
      assign src   = up_vec;
      assign src_v = up_valid;
    end else begin : g_next
      assign src   = vec_r[i-1];
      assign src_v = v_r[i-1];
    end

    // A stage takes new data when it is empty or its successor moves.
    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_comb begin
      dx = src.y >>> i;
      dy = src.x >>> i;
      if (!src.z[ZW-1]) begin
        vec_nxt[i].x = src.x - dx;
        vec_nxt[i].y = src.y + dy;
        vec_nxt[i].z = src.z - atan_lut(ATAN_IDX_W'(i));
      end else begin
        vec_nxt[i].x = src.x + dx;
        vec_nxt[i].y = src.y - dy;
        vec_nxt[i].z = src.z + atan_lut(ATAN_IDX_W'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        vec_r[i] <= vec_nxt[i];
      end
    end
  end

endmodule

// File: hw/rtl/velocity_frame_rotation.sv
// ----------------------------------------------------------------------------
// velocity_frame_rotation: world-frame to robot-frame velocity rotation
// Stages: A, B, C, the 16 CORDIC iteration stages and the output stage O.
// Throughput: one transfer per cycle in and out while out_stall is low; every stage holds on its own.
// Reset: rst_n is synchronous, active low; clears all valid bits and invert_output.
// ----------------------------------------------------------------------------
//
// The heading is reduced modulo 360 degrees, folded into -90..90 degrees
// (negating the vector when the fold takes out half a turn), the vector is
// scaled by the inverse CORDIC gain, rotated through the iteration pipeline,
// rounded to Q3.12, optionally negated and saturated.
//
// Pipeline:
//   A   heading reduction into 0..35999
//   B   quarter-turn fold and input negation
//   C   gain-compensation multiply, one 17 x 31 bit product per component
//   R   one register stage per CORDIC iteration (vfr_cordic)
//   O   rounding, inversion, saturation into the output register
//
// Each stage carries a valid bit and moves when it is empty or its successor
// moves, so a stalled output holds only the stages that are full and bubbles
// are squeezed out while the result waits. in_stall is the inverse of the
// first stage's ready.
//
// invert_output is applied at the output stage; the user must write it only while
// idle (the block does not enforce it), so no item sees a change halfway through.

`include "velocity_frame_rotation_macros.svh"

module velocity_frame_rotation
  import vfr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VEL_WIDTH-1:0] in_world_vx,
  input  logic signed [VEL_WIDTH-1:0] in_world_vy,
  input  logic signed [HEAD_W-1:0]    in_heading,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VEL_WIDTH-1:0] out_robot_vx,
  output logic signed [VEL_WIDTH-1:0] out_robot_vy,
  output logic                        out_clipped
);

  // Heading reduction works one sign bit wider than h + 2 turns needs.
  localparam int RED_W = HEAD_W + 2;
  localparam logic signed [RED_W-1:0] RED_FULL     = RED_W'(36000);
  localparam logic signed [RED_W-1:0] RED_TWO_FULL = RED_W'(72000);
  localparam logic signed [RED_W-1:0] RED_NEG_FULL = RED_W'(-36000);

  localparam logic signed [HEAD_W-1:0] TURN_QUARTER    = HEAD_W'(9000);
  localparam logic signed [HEAD_W-1:0] TURN_HALF       = HEAD_W'(18000);
  localparam logic signed [HEAD_W-1:0] TURN_THREE_QTR  = HEAD_W'(27000);
  localparam logic signed [HEAD_W-1:0] TURN_FULL       = HEAD_W'(36000);

  // Output arithmetic: rounded value, one more bit for negation.
  localparam int SW = RW + 1;
  localparam logic signed [XW-1:0] ROUND_BIAS = XW'(2**(FRAC_SHIFT-1));
  localparam logic signed [SW-1:0] SAT_HI     = SW'(2**(VEL_WIDTH-1) - 1);
  localparam logic signed [SW-1:0] SAT_LO     = SW'(-(2**(VEL_WIDTH-1)));

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic invert_output_r;
  logic invert_output_nxt;
  logic cfg_wr;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_INVERT_OUTPUT);

  always_comb begin
    invert_output_nxt = invert_output_r;
    if (cfg_wr && cfg_hit) begin
      invert_output_nxt = cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) begin
      cfg_prdata = CFG_DATA_W'(invert_output_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_output_r <= 1'b0;
    end else begin
      invert_output_r <= invert_output_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Ready chain
  // --------------------------------------------------------------------------
  logic v_a_r;
  logic v_b_r;
  logic v_c_r;
  logic out_valid_r;
  logic rdy_a;
  logic rdy_b;
  logic rdy_c;
  logic out_ready;
  logic cor_up_ready;
  logic cor_valid;

  assign out_ready = !out_valid_r || !out_stall;
  assign rdy_c     = !v_c_r || cor_up_ready;
  assign rdy_b     = !v_b_r || rdy_c;
  assign rdy_a     = !v_a_r || rdy_b;
  assign in_stall  = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        v_a_r <= in_valid;
      end
      if (rdy_b) begin
        v_b_r <= v_a_r;
      end
      if (rdy_c) begin
        v_c_r <= v_b_r;
      end
      if (out_ready) begin
        out_valid_r <= cor_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: reduce the heading into 0..35999. The four candidates are
  // formed in parallel and the one that lands in range is kept.
  // --------------------------------------------------------------------------
  logic signed [RED_W-1:0]     h_ext;
  logic signed [HEAD_W-1:0]    r_a_nxt;
  logic signed [HEAD_W-1:0]    r_a_r;
  logic signed [VEL_WIDTH-1:0] vx_a_r;
  logic signed [VEL_WIDTH-1:0] vy_a_r;

  always_comb begin
    h_ext = RED_W'(in_heading);
    priority if (h_ext >= RED_FULL) begin
      r_a_nxt = HEAD_W'(h_ext - RED_FULL);
    end else if (!h_ext[RED_W-1]) begin
      r_a_nxt = HEAD_W'(h_ext);
    end else if (h_ext >= RED_NEG_FULL) begin
      r_a_nxt = HEAD_W'(h_ext + RED_FULL);
    end else begin
      r_a_nxt = HEAD_W'(h_ext + RED_TWO_FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      r_a_r  <= r_a_nxt;
      vx_a_r <= in_world_vx;
      vy_a_r <= in_world_vy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: fold into -9000..9000. Angles between a quarter and three
  // quarters of a turn lose half a turn, and the vector is negated instead.
  // Exactly three quarters maps to minus a quarter without negation.
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0]   ang_b_nxt;
  logic signed [ANG_W-1:0]   ang_b_r;
  logic                      neg_b;
  logic signed [VEL_WIDTH:0] vx_wide;
  logic signed [VEL_WIDTH:0] vy_wide;
  logic signed [VEL_WIDTH:0] vx_b_nxt;
  logic signed [VEL_WIDTH:0] vy_b_nxt;
  logic signed [VEL_WIDTH:0] vx_b_r;
  logic signed [VEL_WIDTH:0] vy_b_r;

  always_comb begin
    priority if (r_a_r <= TURN_QUARTER) begin
      ang_b_nxt = ANG_W'(r_a_r);
      neg_b     = 1'b0;
    end else if (r_a_r < TURN_THREE_QTR) begin
      ang_b_nxt = ANG_W'(r_a_r - TURN_HALF);
      neg_b     = 1'b1;
    end else begin
      ang_b_nxt = ANG_W'(r_a_r - TURN_FULL);
      neg_b     = 1'b0;
    end
    vx_wide  = (VEL_WIDTH+1)'(vx_a_r);
    vy_wide  = (VEL_WIDTH+1)'(vy_a_r);
    vx_b_nxt = neg_b ? -vx_wide : vx_wide;
    vy_b_nxt = neg_b ? -vy_wide : vy_wide;
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      ang_b_r <= ang_b_nxt;
      vx_b_r  <= vx_b_nxt;
      vy_b_r  <= vy_b_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: scale both components by the inverse CORDIC gain.
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_x_nxt;
  logic signed [PROD_W-1:0] prod_y_nxt;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [ANG_W-1:0]  ang_c_r;
  vfr_vec_t                 cor_in;

  assign prod_x_nxt = vx_b_r * KINV;
  assign prod_y_nxt = vy_b_r * KINV;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      ang_c_r  <= ang_b_r;
    end
  end

  // The floor shift by KINV_SHIFT is a plain bit select of the product.
  always_comb begin
    cor_in.x = XW'($signed(prod_x_r[PROD_W-1:KINV_SHIFT]));
    cor_in.y = XW'($signed(prod_y_r[PROD_W-1:KINV_SHIFT]));
    cor_in.z = ZW'($signed({ang_c_r, {ANGLE_SHIFT{1'b0}}}));
  end

  // --------------------------------------------------------------------------
  // Rotation pipeline
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] cor_x;
  logic signed [XW-1:0] cor_y;

  vfr_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v_c_r),
    .up_vec   (cor_in),
    .up_ready (cor_up_ready),
    .dn_valid (cor_valid),
    .dn_x     (cor_x),
    .dn_y     (cor_y),
    .dn_ready (out_ready)
  );

  // --------------------------------------------------------------------------
  // Stage O: round half up to Q3.12, negate on request, saturate.
  // --------------------------------------------------------------------------
  logic signed [XW-1:0]        x_biased;
  logic signed [XW-1:0]        y_biased;
  logic signed [SW-1:0]        rx_s;
  logic signed [SW-1:0]        ry_s;
  logic signed [VEL_WIDTH-1:0] rx_sat;
  logic signed [VEL_WIDTH-1:0] ry_sat;
  logic                        clip_x;
  logic                        clip_y;
  logic signed [VEL_WIDTH-1:0] out_vx_r;
  logic signed [VEL_WIDTH-1:0] out_vy_r;
  logic                        out_clip_r;

  always_comb begin
    x_biased = cor_x + ROUND_BIAS;
    y_biased = cor_y + ROUND_BIAS;
    rx_s     = SW'($signed(x_biased[XW-1:FRAC_SHIFT]));
    ry_s     = SW'($signed(y_biased[XW-1:FRAC_SHIFT]));
    if (invert_output_r) begin
      rx_s = -rx_s;
      ry_s = -ry_s;
    end
    clip_x = (rx_s > SAT_HI) || (rx_s < SAT_LO);
    clip_y = (ry_s > SAT_HI) || (ry_s < SAT_LO);
    priority if (rx_s > SAT_HI) begin
      rx_sat = VEL_WIDTH'(SAT_HI);
    end else if (rx_s < SAT_LO) begin
      rx_sat = VEL_WIDTH'(SAT_LO);
    end else begin
      rx_sat = VEL_WIDTH'(rx_s);
    end
    priority if (ry_s > SAT_HI) begin
      ry_sat = VEL_WIDTH'(SAT_HI);
    end else if (ry_s < SAT_LO) begin
      ry_sat = VEL_WIDTH'(SAT_LO);
    end else begin
      ry_sat = VEL_WIDTH'(ry_s);
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_vx_r   <= rx_sat;
      out_vy_r   <= ry_sat;
      out_clip_r <= clip_x | clip_y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_robot_vx = out_vx_r;
  assign out_robot_vy = out_vy_r;
  assign out_clipped  = out_clip_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted transfer always lands in the first stage.
  `VFR_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v_a_r)

  // A full first stage that cannot move keeps its item.
  `VFR_ASSERT_NEXT(a_stage_a_holds, v_a_r && !rdy_b, v_a_r && $stable(r_a_r))

  // The reduced heading lies within one turn.
  `VFR_ASSERT_IMPL(a_reduced_range, v_a_r, !r_a_r[HEAD_W-1] && (r_a_r < TURN_FULL))

  // A clipped result carries a limit value in at least one component.
  `VFR_ASSERT_IMPL(a_clip_at_limit, out_valid_r && out_clip_r,
                   (out_vx_r == VEL_WIDTH'(SAT_HI)) || (out_vx_r == VEL_WIDTH'(SAT_LO)) ||
                   (out_vy_r == VEL_WIDTH'(SAT_HI)) || (out_vy_r == VEL_WIDTH'(SAT_LO)))

endmodule

// File: tb/tb_velocity_frame_rotation.sv
// ----------------------------------------------------------------------------
// Velocity frame rotation testbench
// Drives world-frame velocity commands with headings into the rotator and
// compares every robot-frame result against a behavioral CORDIC predictor.
// The test covers field extremes, heading folding, the output inversion
// register, and long random traffic with bursty input and output stalls.
// ----------------------------------------------------------------------------

module tb_velocity_frame_rotation;
  import vfr_pkg::*;

  // Angle constants in hundredths of a degree.
  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;
  // The angle accumulator counts 1/256 of a hundredth degree.
  localparam int ANGLE_UNITS  = 256;
  localparam int ATAN_ENTRIES = 24;
  localparam int ITERATIONS   = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS
                                                                : ATAN_ENTRIES;
  localparam longint ROUND_BIAS = longint'(1) << (FRAC_SHIFT - 1);

  // The pipeline is 20 deep; allow some slack on top.
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;
  localparam int RESET_CYCLES = 11;

  // Register map. Only the inversion register is decoded; the next word
  // address is unmapped and must be ignored by the block.
  localparam logic [CFG_ADDR_W-1:0] ADDR_INVERT_OUTPUT = {REG_INVERT_OUTPUT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED      = {~REG_INVERT_OUTPUT, 2'b00};

  // One robot-frame result as the block presents it.
  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] vx;
    logic signed [VEL_WIDTH-1:0] vy;
    logic                        clipped;
  } robot_vel_t;

  // Receiver stall behavior, chosen afresh at random when the current mode runs out.
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        cfg_psel    = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]       cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]       cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]       cfg_prdata;
  logic                        cfg_pready;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic signed [VEL_WIDTH-1:0] in_world_vx = '0;
  logic signed [VEL_WIDTH-1:0] in_world_vy = '0;
  logic signed [HEAD_W-1:0]    in_heading  = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic signed [VEL_WIDTH-1:0] out_robot_vx;
  logic signed [VEL_WIDTH-1:0] out_robot_vy;
  logic                        out_clipped;

  // Arctangent of 2^-i in accumulator units, rounded to nearest.
  longint atan_units [ATAN_ENTRIES] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0
  };

  // Results predicted for accepted commands, oldest first.
  robot_vel_t pending_robot_vel[$];
  // Testbench copy of the inversion register.
  logic       invert_setting = 1'b0;
  int         mismatches     = 0;

  velocity_frame_rotation u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_world_vx  (in_world_vx),
    .in_world_vy  (in_world_vy),
    .in_heading   (in_heading),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_robot_vx (out_robot_vx),
    .out_robot_vy (out_robot_vy),
    .out_clipped  (out_clipped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Rotates a world-frame velocity into the robot frame the way the block
  // does it: heading reduced and folded into -90..90 degrees, gain
  // compensation, fixed-point CORDIC iterations, rounding, optional
  // negation and saturation.
  function automatic robot_vel_t rotate_to_robot_frame(
    input logic signed [VEL_WIDTH-1:0] wx,
    input logic signed [VEL_WIDTH-1:0] wy,
    input logic signed [HEAD_W-1:0]    hd,
    input logic                        inv
  );
    longint     x, y, z, turn, dx, dy, vel_max, vel_min;
    int         i;
    robot_vel_t res;
    x = longint'(wx);
    y = longint'(wy);
    // Any 17-bit heading is accepted, so reduce it fully before folding.
    turn = ((longint'(hd) % FULL_TURN) + FULL_TURN) % FULL_TURN;
    if (turn > HALF_TURN) turn -= FULL_TURN;
    // Headings beyond a quarter turn are handled as a half turn back plus
    // a negated vector, which keeps the CORDIC inside its convergence range.
    if (turn > QUARTER_TURN) begin
      turn -= HALF_TURN;
      x = -x;
      y = -y;
    end else if (turn < -QUARTER_TURN) begin
      turn += HALF_TURN;
      x = -x;
      y = -y;
    end
    x = (x * longint'(KINV)) >>> KINV_SHIFT;
    y = (y * longint'(KINV)) >>> KINV_SHIFT;
    z = turn * ANGLE_UNITS;
    for (i = 0; i < ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_units[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_units[i];
      end
    end
    x = (x + ROUND_BIAS) >>> FRAC_SHIFT;
    y = (y + ROUND_BIAS) >>> FRAC_SHIFT;
    if (inv) begin
      x = -x;
      y = -y;
    end
    // Negating the most negative value lands one past the top and clips.
    vel_max = (longint'(1) << (VEL_WIDTH - 1)) - 1;
    vel_min = -vel_max - 1;
    res.clipped = 1'b0;
    if (x > vel_max) begin
      x = vel_max;
      res.clipped = 1'b1;
    end else if (x < vel_min) begin
      x = vel_min;
      res.clipped = 1'b1;
    end
    if (y > vel_max) begin
      y = vel_max;
      res.clipped = 1'b1;
    end else if (y < vel_min) begin
      y = vel_min;
      res.clipped = 1'b1;
    end
    res.vx = x[VEL_WIDTH-1:0];
    res.vy = y[VEL_WIDTH-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // A result transfer happens at a rising edge with out_valid high and
  // out_stall low; each one is matched against the oldest prediction.
  always @(posedge clk) begin
    robot_vel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_robot_vel.size() == 0) begin
        report_mismatch($sformatf("unexpected result vx=%0d vy=%0d clipped=%0b",
                                  out_robot_vx, out_robot_vy, out_clipped));
      end else begin
        want = pending_robot_vel.pop_front();
        if (out_robot_vx !== want.vx)
          report_mismatch($sformatf("robot_vx expected %0d got %0d", want.vx, out_robot_vx));
        if (out_robot_vy !== want.vy)
          report_mismatch($sformatf("robot_vy expected %0d got %0d", want.vy, out_robot_vy));
        if (out_clipped !== want.clipped)
          report_mismatch($sformatf("clipped expected %0b got %0b",
                                    want.clipped, out_clipped));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------

  // The receiver alternates between stretches with no stall, sparse random
  // stalls and long runs of stall and release, so that back pressure lands
  // on every phase of the pipeline.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          run_left   = 0;
  logic        run_stall  = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       stall_mode = STALL_NONE;
        1:       stall_mode = STALL_SPARSE;
        default: stall_mode = STALL_RUNS;
      endcase
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 9) < 3);
      default: begin
        if (run_left == 0) begin
          run_stall = ~run_stall;
          run_left  = $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= run_stall;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender and configuration tasks. All of them start and end at a falling
  // edge, so every input changes only there.
  // --------------------------------------------------------------------------

  // Presents one command and holds it until the transfer happens. Valid is
  // left high so a following command goes out back to back.
  task automatic send_velocity(
    input logic signed [VEL_WIDTH-1:0] wx,
    input logic signed [VEL_WIDTH-1:0] wy,
    input logic signed [HEAD_W-1:0]    hd
  );
    in_valid    <= 1'b1;
    in_world_vx <= wx;
    in_world_vy <= wy;
    in_heading  <= hd;
    do @(posedge clk); while (in_stall);
    pending_robot_vel.push_back(rotate_to_robot_frame(wx, wy, hd, invert_setting));
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Stops sending, waits for every predicted result and then lets the
  // pipeline settle before anything else happens.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_robot_vel.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_INVERT_OUTPUT) invert_setting = data[0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_invert_readback();
    logic [CFG_DATA_W-1:0] want;
    want = {{(CFG_DATA_W-1){1'b0}}, invert_setting};
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr  <= ADDR_INVERT_OUTPUT;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      report_mismatch($sformatf("invert_output read expected %0h got %0h",
                                want, cfg_prdata));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus pickers
  // --------------------------------------------------------------------------

  // Mostly full-range values, some small ones and some of the corners.
  function automatic logic signed [VEL_WIDTH-1:0] pick_velocity();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return VEL_WIDTH'($urandom);
    if (sel < 8) return VEL_WIDTH'(int'($urandom_range(0, 1024)) - 512);
    case ($urandom_range(0, 3))
      0:       return {1'b0, {(VEL_WIDTH-1){1'b1}}};
      1:       return {1'b1, {(VEL_WIDTH-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly headings within one turn either way, some anywhere in the 17-bit
  // range, and some right at the fold boundaries.
  function automatic logic signed [HEAD_W-1:0] pick_heading();
    int sel, base;
    sel = $urandom_range(0, 9);
    if (sel < 7) return HEAD_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
    if (sel < 9) return HEAD_W'($urandom);
    case ($urandom_range(0, 7))
      0:       base = 0;
      1:       base = QUARTER_TURN;
      2:       base = QUARTER_TURN + 1;
      3:       base = HALF_TURN;
      4:       base = HALF_TURN + 1;
      5:       base = HALF_TURN + QUARTER_TURN;
      6:       base = FULL_TURN - 1;
      default: base = FULL_TURN;
    endcase
    return HEAD_W'($urandom_range(0, 1) ? base : -base);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and the fold boundaries of the heading, with the block
  // in its reset configuration.
  task automatic test_directed_extremes();
    send_velocity(16'sh7FFF, 16'sh7FFF, HEAD_W'(0));
    send_velocity(-16'sh8000, -16'sh8000, HEAD_W'(0));
    send_velocity(16'sh7FFF, -16'sh8000, HEAD_W'(4500));
    send_velocity(-16'sh8000, 16'sh7FFF, HEAD_W'(-4500));
    send_velocity(16'sh7FFF, 16'sh7FFF, HEAD_W'(4500));
    send_velocity(VEL_WIDTH'(4096), VEL_WIDTH'(0), HEAD_W'(QUARTER_TURN));
    send_velocity(VEL_WIDTH'(4096), VEL_WIDTH'(0), HEAD_W'(QUARTER_TURN + 1));
    send_velocity(VEL_WIDTH'(0), VEL_WIDTH'(4096), HEAD_W'(-QUARTER_TURN));
    send_velocity(VEL_WIDTH'(0), VEL_WIDTH'(4096), HEAD_W'(-QUARTER_TURN - 1));
    send_velocity(VEL_WIDTH'(4096), VEL_WIDTH'(-4096), HEAD_W'(HALF_TURN));
    send_velocity(VEL_WIDTH'(4096), VEL_WIDTH'(-4096), HEAD_W'(-HALF_TURN));
    send_velocity(VEL_WIDTH'(-4096), VEL_WIDTH'(2048), HEAD_W'(FULL_TURN));
    send_velocity(VEL_WIDTH'(-4096), VEL_WIDTH'(2048), HEAD_W'(-FULL_TURN));
    // Headings outside the stated range still reduce modulo a full turn.
    send_velocity(VEL_WIDTH'(12345), VEL_WIDTH'(-23456), HEAD_W'(65535));
    send_velocity(VEL_WIDTH'(-23456), VEL_WIDTH'(12345), HEAD_W'(-65536));
    send_velocity(VEL_WIDTH'(0), VEL_WIDTH'(0), HEAD_W'(27000));
    send_velocity(VEL_WIDTH'(-1), VEL_WIDTH'(-1), HEAD_W'(-1));
    wait_for_drain();
  endtask

  // Register access, the inversion itself, and the case where negating the
  // most negative value has to clip.
  task automatic test_invert_output();
    check_invert_readback();
    cfg_write(ADDR_INVERT_OUTPUT, '1);
    check_invert_readback();
    send_velocity(-16'sh8000, VEL_WIDTH'(0), HEAD_W'(0));
    send_velocity(VEL_WIDTH'(0), -16'sh8000, HEAD_W'(0));
    send_velocity(-16'sh8000, -16'sh8000, HEAD_W'(HALF_TURN));
    send_velocity(16'sh7FFF, 16'sh7FFF, HEAD_W'(0));
    send_velocity(VEL_WIDTH'(4096), VEL_WIDTH'(4096), HEAD_W'(13500));
    wait_for_drain();
    // A write to an address with no register behind it changes nothing.
    cfg_write(ADDR_UNMAPPED, '0);
    check_invert_readback();
    send_velocity(-16'sh8000, VEL_WIDTH'(4096), HEAD_W'(0));
    wait_for_drain();
    cfg_write(ADDR_INVERT_OUTPUT, '0);
    check_invert_readback();
  endtask

  // Random commands in bursts with random gaps, in phases that alternate
  // the inversion setting. Half way through each phase the sender holds off
  // until the pipeline is empty.
  task automatic test_random_traffic(input int phases, input int items_per_phase);
    int phase, n, burst_left;
    for (phase = 0; phase < phases; phase++) begin
      wait_for_drain();
      cfg_write(ADDR_INVERT_OUTPUT, phase % 2);
      burst_left = 0;
      for (n = 0; n < items_per_phase; n++) begin
        if (n == items_per_phase / 2) wait_for_drain();
        if (burst_left == 0) begin
          // Now and then a long burst gives a stretch with no input gaps.
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
          idle_sender($urandom_range(1, 8));
        end
        send_velocity(pick_velocity(), pick_velocity(), pick_heading());
        burst_left--;
      end
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_invert_output();
    test_random_traffic(4, 110);

    mismatches += pending_robot_vel.size();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
